/* design/ebf_pkg.sv */
// ----------------------------------------------------------------------------
// ebf_pkg
// Shared codes, field widths and control types of the extended bridge finder.
// ----------------------------------------------------------------------------
`default_nettype none

package ebf_pkg;

  // field widths
  localparam int KIND_W = 2;
  localparam int END_W  = 3;
  localparam int CNT_W  = 4;
  localparam int REP_W  = 2;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // report codes
  localparam logic [REP_W-1:0] REP_OK     = 2'd0;
  localparam logic [REP_W-1:0] REP_REJECT = 2'd1;
  localparam logic [REP_W-1:0] REP_BRIDGE = 2'd2;
  localparam logic [REP_W-1:0] REP_DONE   = 2'd3;

  // vertex count minimum and reset value
  localparam logic [CNT_W-1:0] MIN_COUNT   = 4'd3;
  localparam logic [CNT_W-1:0] RESET_COUNT = 4'd8;

  // sequencer to flood unit
  typedef struct packed {
    logic init;
    logic step;
  } flood_ctl_t;

  // flood unit to sequencer
  typedef struct packed {
    logic finish;
    logic gap;
  } flood_sts_t;

endpackage

`default_nettype wire

/* design/extended_bridge_finder_core.sv */
// ----------------------------------------------------------------------------
// extended_bridge_finder_core
// Finds edges whose two endpoints together disconnect an undirected graph.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low. An add or a clear
// gives a single word, which appears on the result ports in the next cycle.
// Unused kinds are dropped and give no word. A find is run by a small
// sequencer that scans vertex pairs in matrix order. For each stored edge it
// runs R flood rounds, in each of which the flood unit ors one adjacency row
// per cycle over the n vertices in use. Here R is the eccentricity of the
// start vertex in the cut graph plus one, at most n-2. A finish state issues
// the done word, which shows in the first cycle after busy falls. Every result
// is valid for exactly one cycle with result_valid_o and cannot be held off.
// last_o marks the final word of a command. The vertex count register is
// written through the cfg channel only while the block is idle, no command is
// offered and no word is on the result ports.
`default_nettype none

module extended_bridge_finder_core
  import ebf_pkg::*;
#(
  parameter int MAX_VERTICES = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [END_W-1:0]  end_a_i,
  input  wire logic [END_W-1:0]  end_b_i,
  // result channel
  output logic                   result_valid_o,
  output logic      [REP_W-1:0]  report_o,
  output logic      [END_W-1:0]  bridge_low_o,
  output logic      [END_W-1:0]  bridge_high_o,
  output logic                   last_o,
  // configuration channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CNT_W-1:0]  cfg_data_i
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int IW = CW + 1;
  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_VERTICES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FLOOD  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [VW-1:0]           lo_q, lo_d;
  logic [VW-1:0]           hi_q, hi_d;
  logic [CNT_W-1:0]        vertex_count_q;
  logic                    rv_q, rv_d;
  logic [REP_W-1:0]        report_q, report_d;
  logic [END_W-1:0]        low_q, low_d;
  logic [END_W-1:0]        high_q, high_d;
  logic                    last_q, last_d;
  logic [CNT_W-1:0]        n_full;
  logic [CW-1:0]           n_c;
  logic                    accept;
  logic                    adv;
  logic                    adj_clr;
  logic                    adj_set;
  logic [VW-1:0]           rd_addr;
  logic [VW-1:0]           flood_addr;
  logic [MAX_VERTICES-1:0] rd_row;
  logic [IW-1:0]           hi_p1;
  logic [IW-1:0]           lo_p2;
  flood_ctl_t              flood_ctl;
  flood_sts_t              flood_sts;

  // vertex count in use, clamped
  always_comb begin
    if (vertex_count_q < MIN_COUNT) begin
      n_full = MIN_COUNT;
    end else if (vertex_count_q > MAX_COUNT) begin
      n_full = MAX_COUNT;
    end else begin
      n_full = vertex_count_q;
    end
  end
  assign n_c = CW'(n_full);

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy && !start && !rv_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= RESET_COUNT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vertex_count_q <= cfg_data_i;
    end
  end

  // next pair in matrix order
  assign hi_p1 = IW'(hi_q) + IW'(1);
  assign lo_p2 = IW'(lo_q) + IW'(2);

  // command sequencer
  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    rv_d      = 1'b0;
    report_d  = REP_OK;
    low_d     = '0;
    high_d    = '0;
    last_d    = 1'b0;
    adj_clr   = 1'b0;
    adj_set   = 1'b0;
    adv       = 1'b0;
    flood_ctl = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_ADD: begin
              rv_d   = 1'b1;
              last_d = 1'b1;
              if ((CNT_W'(end_a_i) >= n_full) || (CNT_W'(end_b_i) >= n_full)) begin
                report_d = REP_REJECT;
              end else begin
                adj_set = (end_a_i != end_b_i);
              end
            end
            KIND_FIND: begin
              lo_d    = VW'(0);
              hi_d    = VW'(1);
              state_d = S_SCAN;
            end
            KIND_CLEAR: begin
              adj_clr = 1'b1;
              rv_d    = 1'b1;
              last_d  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_row[hi_q]) begin
          flood_ctl.init = 1'b1;
          state_d        = S_FLOOD;
        end else begin
          adv = 1'b1;
        end
      end
      S_FLOOD: begin
        flood_ctl.step = 1'b1;
        if (flood_sts.finish) begin
          state_d = S_SCAN;
          adv     = 1'b1;
          if (flood_sts.gap) begin
            rv_d     = 1'b1;
            report_d = REP_BRIDGE;
            low_d    = END_W'(lo_q);
            high_d   = END_W'(hi_q);
          end
        end
      end
      S_FINISH: begin
        rv_d     = 1'b1;
        report_d = REP_DONE;
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (adv) begin
      if (hi_p1 < IW'(n_c)) begin
        hi_d = VW'(hi_p1);
      end else if (lo_p2 < IW'(n_c)) begin
        lo_d = lo_q + VW'(1);
        hi_d = VW'(lo_p2);
      end else begin
        state_d = S_FINISH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
    end
  end

  // pair indexes and result word
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    report_q <= report_d;
    low_q    <= low_d;
    high_q   <= high_d;
    last_q   <= last_d;
  end

  assign rd_addr = (state_q == S_FLOOD) ? flood_addr : lo_q;

  ebf_adj #(
    .MAX_VERTICES (MAX_VERTICES),
    .VW           (VW)
  ) u_adj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (adj_clr),
    .set_i     (adj_set),
    .set_a_i   (VW'(end_a_i)),
    .set_b_i   (VW'(end_b_i)),
    .rd_addr_i (rd_addr),
    .rd_row_o  (rd_row)
  );

  ebf_flood #(
    .MAX_VERTICES (MAX_VERTICES),
    .VW           (VW),
    .CW           (CW)
  ) u_flood (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (flood_ctl),
    .lo_i       (lo_q),
    .hi_i       (hi_q),
    .n_i        (n_c),
    .row_i      (rd_row),
    .row_addr_o (flood_addr),
    .sts_o      (flood_sts)
  );

  assign result_valid_o = rv_q;
  assign report_o       = report_q;
  assign bridge_low_o   = low_q;
  assign bridge_high_o  = high_q;
  assign last_o         = last_q;

  // a find ends with exactly one done word
  a_done_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && (report_o == REP_DONE) && last_o))
    else $error("find ended without done word");

  // a bridge word never closes a command
  a_bridge_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (report_o == REP_BRIDGE)) |-> (!last_o && busy))
    else $error("bridge word marked last or outside a find");

  // endpoints are zero except on bridge words
  a_zero_endpoints: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (report_o != REP_BRIDGE)) |->
      ((bridge_low_o == '0) && (bridge_high_o == '0)))
    else $error("endpoints set on non-bridge word");

  // accepted find keeps the block busy
  a_find_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KIND_FIND)) |=> (busy && !result_valid_o))
    else $error("find did not start");

  // bridge endpoints are ordered
  a_bridge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (report_o == REP_BRIDGE)) |-> (bridge_low_o < bridge_high_o))
    else $error("bridge endpoints out of order");

endmodule

`default_nettype wire

/* design/ebf_adj.sv */
// ----------------------------------------------------------------------------
// ebf_adj
// Adjacency bit matrix: symmetric pair set, full clear, one row read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ebf_adj #(
  parameter int MAX_VERTICES = 8,
  parameter int VW           = 3
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    clr_i,
  input  wire logic                    set_i,
  input  wire logic [VW-1:0]           set_a_i,
  input  wire logic [VW-1:0]           set_b_i,
  input  wire logic [VW-1:0]           rd_addr_i,
  output logic      [MAX_VERTICES-1:0] rd_row_o
);

  logic [MAX_VERTICES-1:0] rows_q [MAX_VERTICES];

  // clear empties every row; a set stores both directions of an edge together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        rows_q[r] <= '0;
      end
    end else if (clr_i) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        rows_q[r] <= '0;
      end
    end else if (set_i) begin
      rows_q[set_a_i][set_b_i] <= 1'b1;
      rows_q[set_b_i][set_a_i] <= 1'b1;
    end
  end

  // row read
  assign rd_row_o = rows_q[rd_addr_i];

endmodule

`default_nettype wire

/* design/ebf_flood.sv */
// ----------------------------------------------------------------------------
// ebf_flood
// Reachability flood with two vertices removed; ors one adjacency row a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ebf_flood
  import ebf_pkg::*;
#(
  parameter int MAX_VERTICES = 8,
  parameter int VW           = 3,
  parameter int CW           = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire flood_ctl_t              ctl_i,
  input  wire logic [VW-1:0]           lo_i,
  input  wire logic [VW-1:0]           hi_i,
  input  wire logic [CW-1:0]           n_i,
  input  wire logic [MAX_VERTICES-1:0] row_i,
  output logic      [VW-1:0]           row_addr_o,
  output flood_sts_t                   sts_o
);

  logic [MAX_VERTICES-1:0] reached_q, reached_d;
  logic [MAX_VERTICES-1:0] frontier_q, frontier_d;
  logic [MAX_VERTICES-1:0] next_q, next_d;
  logic [VW-1:0]           v_q, v_d;
  logic [MAX_VERTICES-1:0] mask;
  logic [MAX_VERTICES-1:0] next_full;
  logic [MAX_VERTICES-1:0] fresh;
  logic [VW-1:0]           start_v;
  logic                    pass_end;

  // vertices in use
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i] = (CW'(i) < n_i);
    end
  end

  // start vertex avoids both removed endpoints
  always_comb begin
    if ((lo_i == VW'(0)) && (hi_i == VW'(1))) begin
      start_v = VW'(2);
    end else if (lo_i == VW'(0)) begin
      start_v = VW'(1);
    end else begin
      start_v = VW'(0);
    end
  end

  assign next_full = next_q | (frontier_q[v_q] ? row_i : '0);
  assign fresh     = next_full & mask & ~reached_q;
  assign pass_end  = ((CW'(v_q) + CW'(1)) == n_i);

  // flood sequencing
  always_comb begin
    reached_d  = reached_q;
    frontier_d = frontier_q;
    next_d     = next_q;
    v_d        = v_q;
    if (ctl_i.init) begin
      reached_d  = (MAX_VERTICES'(1) << lo_i) | (MAX_VERTICES'(1) << hi_i)
                 | (MAX_VERTICES'(1) << start_v);
      frontier_d = MAX_VERTICES'(1) << start_v;
      next_d     = '0;
      v_d        = '0;
    end else if (ctl_i.step) begin
      if (pass_end) begin
        reached_d  = reached_q | fresh;
        frontier_d = fresh;
        next_d     = '0;
        v_d        = '0;
      end else begin
        next_d = next_full;
        v_d    = v_q + VW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reached_q  <= '0;
      frontier_q <= '0;
      next_q     <= '0;
      v_q        <= '0;
    end else begin
      reached_q  <= reached_d;
      frontier_q <= frontier_d;
      next_q     <= next_d;
      v_q        <= v_d;
    end
  end

  assign row_addr_o   = v_q;
  assign sts_o.finish = ctl_i.step && pass_end && (fresh == '0);
  assign sts_o.gap    = ((reached_q | fresh) & mask) != mask;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the extended bridge finder core. A short table of
// directed commands and register writes runs first, then random phases at
// several vertex counts; every result word is checked against a behavioral
// model of the adjacency matrix and the reachability flood.
// ----------------------------------------------------------------------------

module tb_top;
  import ebf_pkg::*;

  localparam int          MAX_V       = 8;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          TAIL_CYCLES = 20;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // one result word
  typedef struct packed {
    logic [REP_W-1:0] report;
    logic [END_W-1:0] low;
    logic [END_W-1:0] high;
    logic             last;
  } bridge_word_t;

  // directed table row
  typedef enum logic {ROW_CMD, ROW_CFG} row_op_e;
  typedef struct packed {
    row_op_e           op;
    logic [KIND_W-1:0] kind;
    logic [END_W-1:0]  a;
    logic [END_W-1:0]  b;
    logic [CNT_W-1:0]  cnt;
    logic              typed;
    logic [REP_W-1:0]  rep;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] kind_i;
  logic [END_W-1:0]  end_a_i;
  logic [END_W-1:0]  end_b_i;
  logic              result_valid_o;
  logic [REP_W-1:0]  report_o;
  logic [END_W-1:0]  bridge_low_o;
  logic [END_W-1:0]  bridge_high_o;
  logic              last_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CNT_W-1:0]  cfg_data_i;

  // model state
  logic [MAX_V-1:0]  adj_rows [MAX_V];
  logic [CNT_W-1:0]  count_reg;
  bridge_word_t      pending_words[$];
  dir_row_t          dir_rows[$];
  int                mismatches;
  int                cycles;

  extended_bridge_finder_core #(
    .MAX_VERTICES(MAX_V)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .end_a_i       (end_a_i),
    .end_b_i       (end_b_i),
    .result_valid_o(result_valid_o),
    .report_o      (report_o),
    .bridge_low_o  (bridge_low_o),
    .bridge_high_o (bridge_high_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("extended_bridge_finder_core: mismatch");
      $finish;
    end
  end

  // clamped vertex count
  function automatic int count_in_use();
    int c;
    c = int'(count_reg);
    if (c < int'(MIN_COUNT)) c = int'(MIN_COUNT);
    if (c > MAX_V) c = MAX_V;
    return c;
  endfunction

  // flood from the start vertex with lo and hi cut out; true if a vertex is missed
  function automatic bit cut_splits(int lo, int hi, int n);
    logic [MAX_V-1:0] mask;
    logic [MAX_V-1:0] reach;
    logic [MAX_V-1:0] front;
    logic [MAX_V-1:0] nxt;
    int               origin;
    mask   = MAX_V'((16'd1 << n) - 16'd1);
    origin = (lo == 0 && hi == 1) ? 2 : ((lo == 0) ? 1 : 0);
    reach  = '0;
    reach[lo]     = 1'b1;
    reach[hi]     = 1'b1;
    reach[origin] = 1'b1;
    front  = '0;
    front[origin] = 1'b1;
    while (front != '0) begin
      nxt = '0;
      for (int v = 0; v < n; v++) begin
        if (front[v]) nxt = nxt | adj_rows[v];
      end
      nxt   = nxt & mask & ~reach;
      reach = reach | nxt;
      front = nxt;
    end
    return (reach & mask) != mask;
  endfunction

  // expected words of one accepted command
  function automatic void predict_words(logic [KIND_W-1:0] k, logic [END_W-1:0] a,
                                        logic [END_W-1:0] b);
    int n;
    n = count_in_use();
    case (k)
      KIND_ADD: begin
        if (int'(a) >= n || int'(b) >= n) begin
          pending_words.push_back('{REP_REJECT, 3'd0, 3'd0, 1'b1});
        end else begin
          if (a != b) begin
            adj_rows[a][b] = 1'b1;
            adj_rows[b][a] = 1'b1;
          end
          pending_words.push_back('{REP_OK, 3'd0, 3'd0, 1'b1});
        end
      end
      KIND_CLEAR: begin
        for (int v = 0; v < MAX_V; v++) adj_rows[v] = '0;
        pending_words.push_back('{REP_OK, 3'd0, 3'd0, 1'b1});
      end
      KIND_FIND: begin
        for (int lo = 0; lo < n; lo++) begin
          for (int hi = lo + 1; hi < n; hi++) begin
            if (adj_rows[lo][hi] && cut_splits(lo, hi, n))
              pending_words.push_back('{REP_BRIDGE, END_W'(lo), END_W'(hi), 1'b0});
          end
        end
        pending_words.push_back('{REP_DONE, 3'd0, 3'd0, 1'b1});
      end
      default: begin
        // unused kind leaves everything as it is
      end
    endcase
  endfunction

  // result checker, samples at the rising edge
  always @(posedge clk_i) begin : check_words
    bridge_word_t w;
    if (rst_ni && result_valid_o) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing pending: report %0d low %0d high %0d last %0d",
               report_o, bridge_low_o, bridge_high_o, last_o);
        mismatches++;
      end else begin
        w = pending_words.pop_front();
        if (report_o !== w.report) begin
          $error("report: expected %0d, got %0d", w.report, report_o);
          mismatches++;
        end
        if (bridge_low_o !== w.low) begin
          $error("bridge_low: expected %0d, got %0d", w.low, bridge_low_o);
          mismatches++;
        end
        if (bridge_high_o !== w.high) begin
          $error("bridge_high: expected %0d, got %0d", w.high, bridge_high_o);
          mismatches++;
        end
        if (last_o !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // sender gap: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one command word and wait until it is taken
  task automatic send_cmd(logic [KIND_W-1:0] k, logic [END_W-1:0] a,
                          logic [END_W-1:0] b, int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start   <= 1'b1;
    kind_i  <= k;
    end_a_i <= a;
    end_b_i <= b;
    do @(posedge clk_i); while (busy);
  endtask

  // hold off until every pending word has come back
  task automatic drain_words();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // vertex count write while idle
  task automatic write_count(logic [CNT_W-1:0] v);
    drain_words();
    repeat (8) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    count_reg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic dir_row_t mk_row(row_op_e op, logic [KIND_W-1:0] k,
                                      logic [END_W-1:0] a, logic [END_W-1:0] b,
                                      logic [CNT_W-1:0] cnt, logic typed,
                                      logic [REP_W-1:0] rep);
    return '{op, k, a, b, cnt, typed, rep};
  endfunction

  // random phase: bursts of adds closed by finds, plus clears and noise
  task automatic run_phase(int items, bit tight);
    int               taken;
    int               n;
    int               r;
    int               burst;
    bit               drained;
    logic [END_W-1:0] a;
    logic [END_W-1:0] b;
    logic [KIND_W-1:0] k;
    taken   = 0;
    drained = 1'b0;
    while (taken < items) begin
      if (!drained && taken >= items / 2) begin
        drain_words();
        drained = 1'b1;
      end
      n = count_in_use();
      r = $urandom_range(0, 99);
      burst = 1;
      if (r >= 22) burst = $urandom_range(1, 6);
      for (int i = 0; i < burst; i++) begin
        a = END_W'($urandom_range(0, 7));
        b = END_W'($urandom_range(0, 7));
        if (r < 6) k = KIND_CLEAR;
        else if (r < 10) k = KIND_UNUSED;
        else if (r < 22) k = KIND_FIND;
        else begin
          k = KIND_ADD;
          if ($urandom_range(0, 99) < 88) begin
            a = END_W'($urandom_range(0, n - 1));
            b = END_W'($urandom_range(0, n - 1));
          end
        end
        send_cmd(k, a, b, tight ? 0 : pick_gap());
        predict_words(k, a, b);
        if (k != KIND_UNUSED) taken++;
      end
      // most bursts of adds end in a search
      if (r >= 22 && $urandom_range(0, 99) < 70) begin
        a = END_W'($urandom_range(0, 7));
        b = END_W'($urandom_range(0, 7));
        send_cmd(KIND_FIND, a, b, tight ? 0 : pick_gap());
        predict_words(KIND_FIND, a, b);
        taken++;
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    logic [CNT_W-1:0] phase_counts [9];
    dir_row_t         row;
    mismatches  = 0;
    count_reg   = RESET_COUNT;
    for (int v = 0; v < MAX_V; v++) adj_rows[v] = '0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    kind_i      = KIND_ADD;
    end_a_i     = '0;
    end_b_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: empty graph, self-loop, duplicate, path, ring, chord,
    // count lowered after adds, count clamping, unused kind, clear
    dir_rows.push_back(mk_row(ROW_CMD, KIND_FIND, 3'd0, 3'd0, 4'd0, 1'b1, REP_DONE));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd0, 3'd1, 4'd0, 1'b1, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd1, 3'd2, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd7, 3'd7, 4'd0, 1'b1, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd1, 3'd0, 4'd0, 1'b1, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd2, 3'd3, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd3, 3'd4, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd4, 3'd5, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd5, 3'd6, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd6, 3'd7, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_FIND, 3'd0, 3'd0, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd7, 3'd0, 4'd0, 1'b1, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_FIND, 3'd7, 3'd7, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd2, 3'd6, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_FIND, 3'd0, 3'd7, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CFG, KIND_ADD, 3'd0, 3'd0, 4'd3, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd0, 3'd5, 4'd0, 1'b1, REP_REJECT));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd7, 3'd2, 4'd0, 1'b1, REP_REJECT));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_FIND, 3'd7, 3'd0, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CFG, KIND_ADD, 3'd0, 3'd0, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_ADD, 3'd3, 3'd3, 4'd0, 1'b1, REP_REJECT));
    dir_rows.push_back(mk_row(ROW_CFG, KIND_ADD, 3'd0, 3'd0, 4'd15, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_UNUSED, 3'd7, 3'd7, 4'd0, 1'b0, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_CLEAR, 3'd5, 3'd2, 4'd0, 1'b1, REP_OK));
    dir_rows.push_back(mk_row(ROW_CMD, KIND_FIND, 3'd0, 3'd0, 4'd0, 1'b1, REP_DONE));
    dir_rows.push_back(mk_row(ROW_CFG, KIND_ADD, 3'd0, 3'd0, 4'd8, 1'b0, REP_OK));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.op == ROW_CFG) begin
        write_count(row.cnt);
      end else begin
        send_cmd(row.kind, row.a, row.b, pick_gap());
        predict_words(row.kind, row.a, row.b);
        if (row.typed) begin
          // single word read straight off the command
          void'(pending_words.pop_back());
          pending_words.push_back('{row.rep, 3'd0, 3'd0, 1'b1});
        end
      end
    end

    // random phases across the count range, clamped values included
    phase_counts = '{4'd3, 4'd15, 4'd0, 4'd5, 4'd6, 4'd8, 4'd4, 4'd7, 4'd10};
    phase_counts[8] = CNT_W'($urandom_range(0, 15));
    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      run_phase(33, (p % 3) == 1);
    end

    // wind down
    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $error("words still pending at end: %0d", pending_words.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("extended_bridge_finder_core: match");
    end else begin
      $display("extended_bridge_finder_core: mismatch");
    end
    $finish;
  end

endmodule
